FILE: src/tcp_option_parser_macros.svh
// Assertion macros shared by the option parser modules
`ifndef TCP_OPTION_PARSER_MACROS_SVH
`define TCP_OPTION_PARSER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define TOP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcp_option_parser: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent
`define TOP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcp_option_parser: next-cycle check failed");

`endif

FILE: src/tcp_opt_pkg.sv
// Shared types and constants of the TCP option parser
package tcp_opt_pkg;

  // Option kinds
  localparam logic [7:0] KIND_EOL    = 8'd0;
  localparam logic [7:0] KIND_NOP    = 8'd1;
  localparam logic [7:0] KIND_MSS    = 8'd2;
  localparam logic [7:0] KIND_WSCALE = 8'd3;
  localparam logic [7:0] KIND_SACK   = 8'd4;
  localparam logic [7:0] KIND_TSTAMP = 8'd8;

  // Option lengths (kind and length bytes included)
  localparam logic [7:0] LEN_MIN    = 8'd2;
  localparam logic [7:0] LEN_MSS    = 8'd4;
  localparam logic [7:0] LEN_WSCALE = 8'd3;
  localparam logic [7:0] LEN_TSTAMP = 8'd10;

  // Segment size after reset
  localparam logic [15:0] MSS_DEFAULT = 16'd536;

  // Parse status codes
  localparam logic [1:0] ST_AREA_END = 2'd0;
  localparam logic [1:0] ST_END_LIST = 2'd1;
  localparam logic [1:0] ST_CORRUPT  = 2'd2;
  localparam logic [1:0] ST_TRUNC    = 2'd3;

  typedef struct packed {
    logic [7:0] option_byte;
    logic       area_last;
    logic       area_empty;
  } in_word_t;

  typedef struct packed {
    logic [15:0] segment_size;
    logic        scale_present;
    logic [7:0]  scale_shift;
    logic        sack_allowed;
    logic        stamp_present;
    logic [31:0] stamp_value;
    logic [31:0] stamp_echo;
    logic [1:0]  parse_status;
  } out_word_t;

  // Result of one step of the walker
  typedef struct packed {
    logic      emit;
    out_word_t word;
  } res_t;

endpackage

FILE: src/tcp_opt_in_if.sv
// Option byte channel: valid/ready with one input word
interface tcp_opt_in_if;
  logic                 valid;
  logic                 ready;
  tcp_opt_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/tcp_opt_out_if.sv
// Parse result channel: valid/ready with one result word
interface tcp_opt_out_if;
  logic                  valid;
  logic                  ready;
  tcp_opt_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/tcp_opt_walk.sv
// Option record walker: per-area parse state and result formation
`include "tcp_option_parser_macros.svh"

module tcp_opt_walk (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  tcp_opt_pkg::in_word_t word,
  input  logic [15:0]           dflt_size,
  output tcp_opt_pkg::res_t     res
);

  // Walk phases
  localparam logic [1:0] PH_KIND  = 2'd0;
  localparam logic [1:0] PH_LEN   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  // Found flag positions
  localparam int FL_SCALE = 0;
  localparam int FL_SACK  = 1;
  localparam int FL_STAMP = 2;

  logic [1:0]  phase_r, phase_nxt, phase_tk;
  logic [7:0]  kind_r, kind_nxt, kind_tk;
  logic [7:0]  len_r, len_nxt, len_tk;
  logic [7:0]  pos_r, pos_nxt, pos_tk;
  logic [63:0] vsh_r, vsh_nxt, vsh_tk;
  logic [15:0] size_r, size_nxt, size_tk;
  logic [7:0]  shift_r, shift_nxt, shift_tk;
  logic [31:0] stamp_r, stamp_nxt, stamp_tk;
  logic [31:0] echo_r, echo_nxt, echo_tk;
  logic [2:0]  flags_r, flags_nxt, flags_tk;
  logic        mss_r, mss_nxt, mss_tk;
  logic [1:0]  stat_r, stat_nxt, stat_tk;
  logic        stop_r, stop_nxt, stop_tk;
  logic        finish;
  logic [1:0]  status;
  logic [7:0]  b;
  logic        val_room;
  logic        walk_clean;

  assign b = word.option_byte;

  // Take one byte into the walk
  always_comb begin
    phase_tk = phase_r;
    kind_tk  = kind_r;
    len_tk   = len_r;
    pos_tk   = pos_r;
    vsh_tk   = vsh_r;
    size_tk  = size_r;
    shift_tk = shift_r;
    stamp_tk = stamp_r;
    echo_tk  = echo_r;
    flags_tk = flags_r;
    mss_tk   = mss_r;
    stat_tk  = stat_r;
    stop_tk  = stop_r;
    finish   = 1'b0;
    if (!stop_r) begin
      unique case (phase_r)
        PH_KIND: begin
          if (b == tcp_opt_pkg::KIND_EOL) begin
            stop_tk = 1'b1;
            stat_tk = tcp_opt_pkg::ST_END_LIST;
          end else if (b != tcp_opt_pkg::KIND_NOP) begin
            kind_tk  = b;
            phase_tk = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b < tcp_opt_pkg::LEN_MIN) begin
            stop_tk = 1'b1;
            stat_tk = tcp_opt_pkg::ST_CORRUPT;
          end else begin
            len_tk = b;
            pos_tk = 8'd0;
            vsh_tk = 64'd0;
            if (b == tcp_opt_pkg::LEN_MIN) begin
              finish = 1'b1;
            end else begin
              phase_tk = PH_VALUE;
            end
          end
        end
        PH_VALUE: begin
          vsh_tk = {vsh_r[55:0], b};
          pos_tk = pos_r + 8'd1;
          if (({1'b0, pos_tk} + {1'b0, tcp_opt_pkg::LEN_MIN}) >= {1'b0, len_r}) begin
            finish = 1'b1;
          end
        end
        default: begin
          phase_tk = PH_KIND;
        end
      endcase
    end
    // Close the option and take its value when the length fits
    if (finish) begin
      phase_tk = PH_KIND;
      case (kind_tk)
        tcp_opt_pkg::KIND_MSS: begin
          if (len_tk == tcp_opt_pkg::LEN_MSS) begin
            size_tk = vsh_tk[15:0];
            mss_tk  = 1'b1;
          end
        end
        tcp_opt_pkg::KIND_WSCALE: begin
          if (len_tk == tcp_opt_pkg::LEN_WSCALE) begin
            shift_tk           = vsh_tk[7:0];
            flags_tk[FL_SCALE] = 1'b1;
          end
        end
        tcp_opt_pkg::KIND_SACK: begin
          flags_tk[FL_SACK] = 1'b1;
        end
        tcp_opt_pkg::KIND_TSTAMP: begin
          if (len_tk == tcp_opt_pkg::LEN_TSTAMP) begin
            stamp_tk           = vsh_tk[63:32];
            echo_tk            = vsh_tk[31:0];
            flags_tk[FL_STAMP] = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Form the result word
  always_comb begin
    if (stop_tk) begin
      status = stat_tk;
    end else if (phase_tk != PH_KIND) begin
      status = tcp_opt_pkg::ST_TRUNC;
    end else begin
      status = tcp_opt_pkg::ST_AREA_END;
    end
    res.emit = word.area_last || word.area_empty;
    if (word.area_empty) begin
      res.word              = '0;
      res.word.segment_size = dflt_size;
    end else begin
      res.word.segment_size  = mss_tk ? size_tk : dflt_size;
      res.word.scale_present = flags_tk[FL_SCALE];
      res.word.scale_shift   = flags_tk[FL_SCALE] ? shift_tk : 8'd0;
      res.word.sack_allowed  = flags_tk[FL_SACK];
      res.word.stamp_present = flags_tk[FL_STAMP];
      res.word.stamp_value   = flags_tk[FL_STAMP] ? stamp_tk : 32'd0;
      res.word.stamp_echo    = flags_tk[FL_STAMP] ? echo_tk : 32'd0;
      res.word.parse_status  = status;
    end
  end

  // Clear per-area state after every result, else keep the walked state
  always_comb begin
    if (res.emit) begin
      phase_nxt = PH_KIND;
      kind_nxt  = 8'd0;
      len_nxt   = 8'd0;
      pos_nxt   = 8'd0;
      vsh_nxt   = 64'd0;
      size_nxt  = tcp_opt_pkg::MSS_DEFAULT;
      shift_nxt = 8'd0;
      stamp_nxt = 32'd0;
      echo_nxt  = 32'd0;
      flags_nxt = 3'd0;
      mss_nxt   = 1'b0;
      stat_nxt  = tcp_opt_pkg::ST_AREA_END;
      stop_nxt  = 1'b0;
    end else begin
      phase_nxt = phase_tk;
      kind_nxt  = kind_tk;
      len_nxt   = len_tk;
      pos_nxt   = pos_tk;
      vsh_nxt   = vsh_tk;
      size_nxt  = size_tk;
      shift_nxt = shift_tk;
      stamp_nxt = stamp_tk;
      echo_nxt  = echo_tk;
      flags_nxt = flags_tk;
      mss_nxt   = mss_tk;
      stat_nxt  = stat_tk;
      stop_nxt  = stop_tk;
    end
  end

  // Advance the walk state on each consumed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_KIND;
      kind_r  <= 8'd0;
      len_r   <= 8'd0;
      pos_r   <= 8'd0;
      vsh_r   <= 64'd0;
      size_r  <= tcp_opt_pkg::MSS_DEFAULT;
      shift_r <= 8'd0;
      stamp_r <= 32'd0;
      echo_r  <= 32'd0;
      flags_r <= 3'd0;
      mss_r   <= 1'b0;
      stat_r  <= tcp_opt_pkg::ST_AREA_END;
      stop_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      vsh_r   <= vsh_nxt;
      size_r  <= size_nxt;
      shift_r <= shift_nxt;
      stamp_r <= stamp_nxt;
      echo_r  <= echo_nxt;
      flags_r <= flags_nxt;
      mss_r   <= mss_nxt;
      stat_r  <= stat_nxt;
      stop_r  <= stop_nxt;
    end
  end

  // Value bytes still owed by the open option, and a fully cleared walk
  assign val_room   = ({1'b0, pos_r} + 9'd2) < {1'b0, len_r};
  assign walk_clean = (phase_r == PH_KIND) && !stop_r && (flags_r == 3'd0) && !mss_r;

  // A value phase always belongs to an option with value bytes left
  `TOP_ASSERT_IMP(a_value_len, clk, rst_n, phase_r == PH_VALUE, len_r > tcp_opt_pkg::LEN_MIN)
  `TOP_ASSERT_IMP(a_value_pos, clk, rst_n, phase_r == PH_VALUE, val_room)
  // An empty area leaves a clean walk behind
  `TOP_ASSERT_NXT(a_empty_clr, clk, rst_n, step && word.area_empty, walk_clean)

endmodule

FILE: src/tcp_option_parser.sv
// Top level of the TCP option parser: channels, config register and staging
//
//   channel | direction | handshake        | word
//   in_ch   | sink      | valid/ready      | option_byte, area_last, area_empty
//   out_ch  | source    | valid/ready      | segment_size .. parse_status
//   cfg     | slave     | APB write/read   | default_segment_size at address 0
//
// One option byte is taken every clock while no stalled result holds it back; the
// result of the byte that ends the area passes the input register, then the result register.
// Reset is synchronous on rst_n and clears the walk and both stage valids.
// While the result register is held by a stalled sink, one more word waits in
// the input register; words that end no area keep flowing through the walker.
`include "tcp_option_parser_macros.svh"

module tcp_option_parser (
  input  logic                clk,
  input  logic                rst_n,
  tcp_opt_in_if.sink          in_ch,
  tcp_opt_out_if.source       out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Register index from the word address
  localparam logic REG_DEFAULT_SIZE = 1'b0;

  logic [15:0]            dflt_size_r;
  logic                   s1_valid_r;
  tcp_opt_pkg::in_word_t  s1_word_r;
  logic                   out_valid_r;
  tcp_opt_pkg::out_word_t out_word_r;
  tcp_opt_pkg::res_t      res;
  logic                   s1_go;
  logic                   cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_DEFAULT_SIZE) ? {16'd0, dflt_size_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_size_r <= tcp_opt_pkg::MSS_DEFAULT;
    end else if (cfg_wr && (paddr[2] == REG_DEFAULT_SIZE)) begin
      dflt_size_r <= pwdata[15:0];
    end
  end

  // Advance the input word when its result, if any, has a free slot
  assign s1_go       = s1_valid_r && (!res.emit || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_word_r <= in_ch.data;
    end
  end

  tcp_opt_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .word      (s1_word_r),
    .dflt_size (dflt_size_r),
    .res       (res)
  );

  // Result register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res.emit) begin
      out_word_r <= res.word;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  // A waiting result is never overwritten or lost
  `TOP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid_r && !out_ch.ready, out_valid_r)
  `TOP_ASSERT_IMP(a_no_clobber, clk, rst_n, s1_go && res.emit && out_valid_r, out_ch.ready)
  `TOP_ASSERT_NXT(a_emit_load, clk, rst_n, s1_go && res.emit, out_valid_r)
  `TOP_ASSERT_IMP(a_empty_ready, clk, rst_n, !s1_valid_r, in_ch.ready)

endmodule
